/* src/kct_pkg.sv */
// Package for the keyed count table: sizes, command and status codes,
// and the operation and result records passed between the front and back.
// No dependencies.
package kct_pkg;

   localparam int CAPACITY  = 16;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int DATA_W    = 32;

   // Both queue depths must be powers of two so that the pointers wrap freely.
   localparam int OPQ_DEPTH = 4;
   localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
   localparam int RSQ_DEPTH = 2;
   localparam int RSQ_PTR_W = $clog2(RSQ_DEPTH);
   localparam int RSQ_CNT_W = $clog2(RSQ_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_FULL    = 3'd2,
      ST_MISSING = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // What the back end does with the count memory for one operation.
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_UPDATE = 2'd2,
      OP_CONST  = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      status_type                status;
      logic [IDX_W-1:0]          idx;
      logic signed [DATA_W-1:0]  key;
      logic signed [DATA_W-1:0]  amount;
      logic                      last;
   } op_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  key;
      logic signed [DATA_W-1:0]  count;
      logic                      last;
   } result_type;

endpackage

/* src/kct_front.sv */
// Front end of the keyed count table: takes commands, compares the key against
// every stored key at once, keeps keys and their sort ranks, and issues operations.
// Depends on kct_pkg.
module kct_front import kct_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_command,
   input  logic signed [DATA_W-1:0]  req_key,
   input  logic signed [DATA_W-1:0]  req_amount,
   output logic                      op_push,
   output op_type                    op_data,
   input  logic                      op_full
);

   typedef enum logic [1:0] {F_IDLE, F_LOOK, F_ISSUE, F_LIST} fstate_type;

   fstate_type                state_ff, state_in;
   cmd_type                   item_cmd_ff, item_cmd_in;
   logic signed [DATA_W-1:0]  item_key_ff, item_key_in;
   logic signed [DATA_W-1:0]  item_amount_ff, item_amount_in;
   logic [CAPACITY-1:0]       match_ff, match_in;
   logic [CAPACITY-1:0]       less_ff, less_in;
   logic [IDX_W-1:0]          walk_ff, walk_in;
   logic [CNT_W-1:0]          entry_count_ff, entry_count_in;
   logic signed [DATA_W-1:0]  key_store_ff [CAPACITY];
   logic [IDX_W-1:0]          rank_ff [CAPACITY];

   logic [CAPACITY-1:0]       valid_vec;
   logic [CAPACITY-1:0]       sel_vec;
   logic [IDX_W-1:0]          hit_idx;
   logic [IDX_W-1:0]          sel_idx;
   logic signed [DATA_W-1:0]  sel_key;
   logic [CNT_W-1:0]          less_cnt;
   logic [CNT_W-1:0]          last_rank;
   logic                      hit;
   logic                      table_full;
   logic                      list_walk;
   logic                      op_valid;
   logic                      accept;
   logic                      can_take;
   logic                      ins_en;

   always_comb begin
      valid_vec = '0;
      sel_vec   = '0;
      match_in  = match_ff;
      less_in   = less_ff;
      hit_idx   = '0;
      sel_idx   = '0;
      sel_key   = '0;
      less_cnt  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         valid_vec[i] = CNT_W'(i) < entry_count_ff;
         sel_vec[i]   = valid_vec[i] && (rank_ff[i] == walk_ff);
         if (state_ff == F_LOOK) begin
            match_in[i] = valid_vec[i] && (key_store_ff[i] == item_key_ff);
            less_in[i]  = valid_vec[i] && (key_store_ff[i] < item_key_ff);
         end
         if (match_ff[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
         if (sel_vec[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
            sel_key = sel_key | key_store_ff[i];
         end
         less_cnt = less_cnt + CNT_W'(less_ff[i]);
      end
   end

   assign hit        = |match_ff;
   assign table_full = entry_count_ff == CNT_W'(CAPACITY);
   assign list_walk  = (item_cmd_ff == CMD_LIST) && (entry_count_ff != '0);
   assign last_rank  = entry_count_ff - CNT_W'(1);

   always_comb begin
      op_valid        = 1'b0;
      op_data.kind    = OP_CONST;
      op_data.status  = ST_OK;
      op_data.idx     = hit_idx;
      op_data.key     = item_key_ff;
      op_data.amount  = item_amount_ff;
      op_data.last    = 1'b1;
      ins_en          = 1'b0;
      unique case (state_ff)
         F_ISSUE: begin
            op_valid = !list_walk;
            unique case (item_cmd_ff)
               CMD_INSERT: begin
                  if (table_full) begin
                     op_data.status = ST_FULL;
                  end else if (hit) begin
                     op_data.kind   = OP_READ;
                     op_data.status = ST_DUP;
                  end else begin
                     op_data.kind = OP_WRITE;
                     op_data.idx  = entry_count_ff[IDX_W-1:0];
                     ins_en       = !op_full;
                  end
               end
               CMD_SEARCH, CMD_UPDATE: begin
                  if (hit) begin
                     op_data.kind = (item_cmd_ff == CMD_UPDATE) ? OP_UPDATE : OP_READ;
                  end else begin
                     op_data.status = ST_MISSING;
                  end
               end
               CMD_LIST: begin
                  op_data.status = ST_EMPTY;
                  op_data.key    = '0;
               end
               default: op_data.status = ST_OK;
            endcase
         end
         F_LIST: begin
            op_valid     = 1'b1;
            op_data.kind = OP_READ;
            op_data.idx  = sel_idx;
            op_data.key  = sel_key;
            op_data.last = walk_ff == last_rank[IDX_W-1:0];
         end
         default: op_valid = 1'b0;
      endcase
   end

   assign op_push  = op_valid && !op_full;
   // A new command may enter in the cycle the previous one leaves the issue stage.
   assign can_take = (state_ff == F_IDLE) ||
                     ((state_ff == F_ISSUE) && !list_walk && !op_full);
   assign req_full = !can_take;
   assign accept   = req_push && can_take;

   always_comb begin
      state_in       = state_ff;
      walk_in        = walk_ff;
      entry_count_in = ins_en ? entry_count_ff + CNT_W'(1) : entry_count_ff;
      item_cmd_in    = accept ? cmd_type'(req_command) : item_cmd_ff;
      item_key_in    = accept ? req_key : item_key_ff;
      item_amount_in = accept ? req_amount : item_amount_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_LOOK;
            end
         end
         F_LOOK: state_in = F_ISSUE;
         F_ISSUE: begin
            if (list_walk) begin
               state_in = F_LIST;
               walk_in  = '0;
            end else if (!op_full) begin
               state_in = accept ? F_LOOK : F_IDLE;
            end
         end
         F_LIST: begin
            if (op_push) begin
               walk_in = walk_ff + IDX_W'(1);
               if (op_data.last) begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         entry_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
      end
      item_cmd_ff    <= item_cmd_in;
      item_key_ff    <= item_key_in;
      item_amount_ff <= item_amount_in;
      match_ff       <= match_in;
      less_ff        <= less_in;
      walk_ff        <= walk_in;
      // A new key takes the rank of the keys below it; every larger key moves up one.
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_en) begin
            if (CNT_W'(i) == entry_count_ff) begin
               key_store_ff[i] <= item_key_ff;
               rank_ff[i]      <= less_cnt[IDX_W-1:0];
            end else if (valid_vec[i] && !less_ff[i]) begin
               rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

endmodule

/* src/kct_opq.sv */
// Short operation queue between the front and back ends of the keyed count table.
// Depends on kct_pkg.
module kct_opq import kct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  op_type  push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output op_type  pop_data
);

   op_type                slot_ff [OPQ_DEPTH];
   logic [OPQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_W-1:0]  fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = fill_ff == OPQ_CNT_W'(OPQ_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + OPQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + OPQ_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + OPQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - OPQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/kct_back.sv */
// Back end of the keyed count table: holds the count memory, carries out reads,
// writes and saturating updates, and queues the results. Depends on kct_pkg.
module kct_back import kct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        op_valid,
   input  op_type      op_data,
   output logic        op_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output result_type  rsp_data
);

   typedef enum logic {B_IDLE, B_WAIT} bstate_type;

   bstate_type                bstate_ff, bstate_in;
   op_type                    cur_ff, cur_in;
   logic signed [DATA_W-1:0]  rd_data_ff;
   logic signed [DATA_W-1:0]  count_mem [CAPACITY];
   result_type                rq_ff [RSQ_DEPTH];
   logic [RSQ_PTR_W-1:0]      rq_wr_ff, rq_wr_in;
   logic [RSQ_PTR_W-1:0]      rq_rd_ff, rq_rd_in;
   logic [RSQ_CNT_W-1:0]      rq_cnt_ff, rq_cnt_in;

   logic                      room;
   logic                      rd_en;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_addr;
   logic signed [DATA_W-1:0]  mem_wdata;
   logic                      res_push;
   result_type                res;
   logic                      res_pop;
   logic signed [DATA_W:0]    sum_wide;
   logic signed [DATA_W-1:0]  sum_sat;

   assign room = rq_cnt_ff < RSQ_CNT_W'(RSQ_DEPTH);

   // Saturating add: overflow shows as the two top bits of the wide sum differing.
   always_comb begin
      sum_wide = {rd_data_ff[DATA_W-1], rd_data_ff} + {cur_ff.amount[DATA_W-1], cur_ff.amount};
      if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
         sum_sat = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[DATA_W-1:0];
      end
   end

   always_comb begin
      bstate_in    = bstate_ff;
      cur_in       = cur_ff;
      op_pop       = 1'b0;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = op_data.idx;
      mem_wdata    = op_data.amount;
      res_push     = 1'b0;
      res.status   = op_data.status;
      res.key      = op_data.key;
      res.count    = '0;
      res.last     = op_data.last;
      unique case (bstate_ff)
         B_IDLE: begin
            if (op_valid && room) begin
               op_pop = 1'b1;
               unique case (op_data.kind)
                  OP_WRITE: begin
                     mem_we    = 1'b1;
                     res_push  = 1'b1;
                     res.count = op_data.amount;
                  end
                  OP_CONST: res_push = 1'b1;
                  OP_READ, OP_UPDATE: begin
                     rd_en     = 1'b1;
                     cur_in    = op_data;
                     bstate_in = B_WAIT;
                  end
                  default: res_push = 1'b0;
               endcase
            end
         end
         B_WAIT: begin
            res_push   = 1'b1;
            res.status = cur_ff.status;
            res.key    = cur_ff.key;
            res.last   = cur_ff.last;
            res.count  = rd_data_ff;
            mem_addr   = cur_ff.idx;
            mem_wdata  = sum_sat;
            if (cur_ff.kind == OP_UPDATE) begin
               mem_we    = 1'b1;
               res.count = sum_sat;
            end
            bstate_in = B_IDLE;
         end
         default: bstate_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_addr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= count_mem[op_data.idx];
      end
   end

   assign rsp_empty = rq_cnt_ff == '0;
   assign res_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in  = res_push ? rq_wr_ff + RSQ_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = res_pop ? rq_rd_ff + RSQ_PTR_W'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (res_push && !res_pop) begin
         rq_cnt_in = rq_cnt_ff + RSQ_CNT_W'(1);
      end else if (res_pop && !res_push) begin
         rq_cnt_in = rq_cnt_ff - RSQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_IDLE;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         bstate_ff <= bstate_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
      cur_ff <= cur_in;
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule

/* src/keyed_count_table.sv */
// Keyed count table: a table of up to CAPACITY unique signed keys with a signed
// count each, driven by insert, search, update and sorted-list commands.
// Depends on kct_pkg, kct_front, kct_opq and kct_back.
//
// Insert, search and update commands pass through a look state and an issue state:
// the front end first compares the key with all stored keys at once, then classifies
// and issues the operation, and a new command may enter as the previous one leaves
// the issue stage. A list command holds the front end until it has issued a read for
// every stored entry and yields the entries in ascending key order, the last one
// marked. The back end handles a write or a status result in its idle state and adds
// a wait state for anything that reads the count memory, whose read data is registered;
// a four-entry queue separates the two ends, and a two-entry result queue lets commands
// keep arriving while a result waits to be popped.
module keyed_count_table import kct_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_command,
   input  logic signed [DATA_W-1:0]  req_key,
   input  logic signed [DATA_W-1:0]  req_amount,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_status,
   output logic signed [DATA_W-1:0]  rsp_key_out,
   output logic signed [DATA_W-1:0]  rsp_count_out,
   output logic                      rsp_last
);

   logic        opq_push;
   logic        opq_full;
   logic        opq_empty;
   logic        opq_pop;
   op_type      opq_in;
   op_type      opq_out;
   result_type  rsp_data;

   kct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_key     (req_key),
      .req_amount  (req_amount),
      .op_push     (opq_push),
      .op_data     (opq_in),
      .op_full     (opq_full)
   );

   kct_opq u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (opq_push),
      .push_data (opq_in),
      .full      (opq_full),
      .pop       (opq_pop),
      .empty     (opq_empty),
      .pop_data  (opq_out)
   );

   kct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!opq_empty),
      .op_data   (opq_out),
      .op_pop    (opq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_status    = rsp_data.status;
   assign rsp_key_out   = rsp_data.key;
   assign rsp_count_out = rsp_data.count;
   assign rsp_last      = rsp_data.last;

endmodule

/* src/kct_checker.sv */
// Port-level checks for the keyed count table, bound to the top level.
// Depends on kct_pkg and keyed_count_table.
module kct_checker import kct_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_push,
   input logic                      req_full,
   input logic [1:0]                req_command,
   input logic signed [DATA_W-1:0]  req_key,
   input logic signed [DATA_W-1:0]  req_amount,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input logic [2:0]                rsp_status,
   input logic signed [DATA_W-1:0]  rsp_key_out,
   input logic signed [DATA_W-1:0]  rsp_count_out,
   input logic                      rsp_last
);

   // After reset the table is ready for a command and has nothing to report.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("table not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_status) &&
         $stable(rsp_key_out) && $stable(rsp_count_out) && $stable(rsp_last)))
      else $error("waiting result changed before its transfer");

   // Only list results carry on past one result, and they are always ok.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status != ST_OK)) |-> rsp_last)
      else $error("non-ok result not marked last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && ((rsp_status == ST_FULL) || (rsp_status == ST_MISSING) ||
         (rsp_status == ST_EMPTY))) |-> (rsp_count_out == '0))
      else $error("failure result carries a non-zero count");

   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == ST_EMPTY)) |-> (rsp_key_out == '0))
      else $error("empty-table result carries a non-zero key");

endmodule

bind keyed_count_table kct_checker u_kct_checker (.*);

/* tb/sv/keyed_count_table_test.sv */
// Self-checking testbench for keyed_count_table: a directed opening, random commands
// against a scoreboard that keeps its own copy of the table, then a closing fill.
// Depends on kct_pkg and keyed_count_table.
`timescale 1ns / 100ps

module keyed_count_table_test;
   import kct_pkg::*;

   localparam int RANDOM_ITEMS     = 230;
   localparam int HOLD_CYCLES      = 80;
   localparam int DRAIN_CYCLES     = 30;
   localparam int RUN_LIMIT_CYCLES = 200_000;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   // Keeps a shadow of the table and the results still owed by the block.
   class count_table_board;
      result_type               owed_results[$];
      logic signed [DATA_W-1:0] key_tab[CAPACITY];
      logic signed [DATA_W-1:0] count_tab[CAPACITY];
      int                       entries = 0;
      int                       failures = 0;

      function int find(logic signed [DATA_W-1:0] key);
         for (int i = 0; i < entries; i++)
            if (key_tab[i] == key)
               return i;
         return -1;
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      function void queue_result(status_type status, logic signed [DATA_W-1:0] key,
                                 logic signed [DATA_W-1:0] count, logic last);
         result_type r;
         r.status = status;
         r.key    = key;
         r.count  = count;
         r.last   = last;
         owed_results.push_back(r);
      endfunction

      function void note_command(cmd_type cmd, logic signed [DATA_W-1:0] key,
                                 logic signed [DATA_W-1:0] amount);
         int     slot;
         int     j;
         longint sum;
         int     order[CAPACITY];
         slot = find(key);
         case (cmd)
            CMD_INSERT: begin
               // A full table is reported even when the key is already present.
               if (entries >= CAPACITY)
                  queue_result(ST_FULL, key, '0, 1'b1);
               else if (slot >= 0)
                  queue_result(ST_DUP, key, count_tab[slot], 1'b1);
               else begin
                  key_tab[entries]   = key;
                  count_tab[entries] = amount;
                  entries++;
                  queue_result(ST_OK, key, amount, 1'b1);
               end
            end
            CMD_SEARCH, CMD_UPDATE: begin
               if (slot < 0)
                  queue_result(ST_MISSING, key, '0, 1'b1);
               else begin
                  if (cmd == CMD_UPDATE) begin
                     sum = longint'(count_tab[slot]) + longint'(amount);
                     if (sum > longint'(VAL_MAX))
                        sum = longint'(VAL_MAX);
                     else if (sum < longint'(VAL_MIN))
                        sum = longint'(VAL_MIN);
                     count_tab[slot] = sum[DATA_W-1:0];
                  end
                  queue_result(ST_OK, key, count_tab[slot], 1'b1);
               end
            end
            default: begin
               if (entries == 0)
                  queue_result(ST_EMPTY, '0, '0, 1'b1);
               else begin
                  for (int i = 0; i < entries; i++) begin
                     j = i;
                     while (j > 0 && key_tab[i] < key_tab[order[j-1]]) begin
                        order[j] = order[j-1];
                        j--;
                     end
                     order[j] = i;
                  end
                  for (int i = 0; i < entries; i++)
                     queue_result(ST_OK, key_tab[order[i]], count_tab[order[i]],
                                  i == entries - 1);
               end
            end
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            $error("unexpected result: status %0d, key_out %0d, count_out %0d, last %0b",
                   got.status, got.key, got.count, got.last);
            failures++;
            return;
         end
         want = owed_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.key !== want.key) begin
            $error("key_out: expected %0d, actual %0d", want.key, got.key);
            failures++;
         end
         if (got.count !== want.count) begin
            $error("count_out: expected %0d, actual %0d", want.count, got.count);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [1:0]                req_command = CMD_INSERT;
   logic signed [DATA_W-1:0]  req_key = '0;
   logic signed [DATA_W-1:0]  req_amount = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [2:0]                rsp_status;
   logic signed [DATA_W-1:0]  rsp_key_out;
   logic signed [DATA_W-1:0]  rsp_count_out;
   logic                      rsp_last;

   count_table_board board = new;
   bit               steady = 1'b0;
   bit               hold_request = 1'b0;

   keyed_count_table dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_amount    (req_amount),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_key_out   (rsp_key_out),
      .rsp_count_out (rsp_count_out),
      .rsp_last      (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [DATA_W-1:0] random_value();
      logic signed [DATA_W-1:0] v;
      int                       roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         case ($urandom_range(0, 4))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2:       v = '0;
            3:       v = 1;
            default: v = -1;
         endcase
      end else if (roll < 50) begin
         v = $urandom_range(0, 100);
         v = v - 50;
      end else
         v = $urandom;
      return v;
   endfunction

   task automatic push_command(cmd_type cmd, logic signed [DATA_W-1:0] key,
                               logic signed [DATA_W-1:0] amount);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < 34)
            gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      req_amount  <= amount;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      board.note_command(cmd, key, amount);
   endtask

   // The last transfer always leaves a result owed, so the loop always waits on the clock.
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
   endtask

   // Result side: random stalls, a steady stretch, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (reset)
            rsp_pop <= 1'b0;
         else if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request <= 1'b0;
         end else
            rsp_pop <= steady || ($urandom_range(0, 99) >= 34);
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.status = status_type'(rsp_status);
         got.key    = rsp_key_out;
         got.count  = rsp_count_out;
         got.last   = rsp_last;
         board.check_result(got);
      end
   end

   initial begin
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] key;
      int                       roll;
      bit                       reuse;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty table, saturation both ways, duplicates, sorting.
      push_command(CMD_LIST,   32'sd0,  32'sd0);
      push_command(CMD_SEARCH, 32'sd5,  VAL_MAX);
      push_command(CMD_UPDATE, 32'sd5,  32'sd1);
      push_command(CMD_INSERT, VAL_MAX, VAL_MAX);
      push_command(CMD_INSERT, VAL_MIN, VAL_MIN);
      push_command(CMD_INSERT, 32'sd0,  32'sd0);
      push_command(CMD_INSERT, -32'sd1, -32'sd1);
      push_command(CMD_INSERT, VAL_MAX, 32'sd7);
      push_command(CMD_SEARCH, VAL_MIN, 32'sd0);
      push_command(CMD_SEARCH, 32'sd12345, 32'sd0);
      push_command(CMD_UPDATE, VAL_MAX, 32'sd1);
      push_command(CMD_UPDATE, VAL_MIN, -32'sd1);
      push_command(CMD_UPDATE, 32'sd0,  VAL_MAX);
      push_command(CMD_UPDATE, 32'sd0,  VAL_MIN);
      push_command(CMD_UPDATE, -32'sd1, VAL_MIN);
      push_command(CMD_LIST,   VAL_MIN, VAL_MAX);
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 40)
            hold_request <= 1'b1;
         if (n == 180)
            wait_for_results();
         steady = (n >= 110 && n < 160);
         roll = $urandom_range(0, 99);
         if (roll < 25)
            cmd = CMD_INSERT;
         else if (roll < 55)
            cmd = CMD_SEARCH;
         else if (roll < 90)
            cmd = CMD_UPDATE;
         else
            cmd = CMD_LIST;
         // Searches and updates mostly hit stored keys; some inserts repeat one.
         reuse = board.entries > 0 &&
                 $urandom_range(0, 99) < (cmd == CMD_INSERT ? 30 : 75);
         if (reuse)
            key = board.key_tab[$urandom_range(0, board.entries - 1)];
         else
            key = random_value();
         push_command(cmd, key, random_value());
      end
      steady = 1'b0;

      // Make sure the table is full, then show that full is reported before duplicate.
      while (board.entries < CAPACITY) begin
         key = $urandom;
         if (board.find(key) < 0)
            push_command(CMD_INSERT, key, random_value());
      end
      push_command(CMD_INSERT, board.key_tab[0], 32'sd3);
      do
         key = $urandom;
      while (board.find(key) >= 0);
      push_command(CMD_INSERT, key, VAL_MIN);
      push_command(CMD_LIST, 32'sd0, 32'sd0);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * 20);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
